@@ design/bm3t_pkg.sv @@
package bm3t_pkg;

    // Fixed field widths
    localparam int PIX_W      = 5;
    localparam int ROW_W      = 16;
    localparam int COLUMN_W   = 10;
    localparam int FWIDTH_W   = 11;
    localparam int FHEIGHT_W  = 16;
    localparam int THR_W      = 5;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Register reset values
    localparam logic [FWIDTH_W-1:0]  FRAME_WIDTH_RST    = 11'd1024;
    localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RST   = 16'd1024;
    localparam logic [THR_W-1:0]     MEAN_THRESHOLD_RST = 5'd6;
    localparam logic [PIX_W-1:0]     PIXEL_LIMIT_RST    = 5'd20;

    // Item kinds
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_MEAN_THRESHOLD = 2'd2,
        CFG_PIXEL_LIMIT    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] pixel_value;
    } pixel_in_t;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COLUMN_W-1:0] column;
        logic                marked;
        logic                end_of_frame;
    } mark_out_t;

endpackage

@@ design/box_mean_3x3_threshold_mark.sv @@
// 3x3 box-mean threshold marker for a raster pixel stream.
//
// Input channel (s_valid/s_ready/s_data): one pixel or flush item per transfer,
// in raster order. After the last pixel of a frame the host sends width+1 flush
// items so the last marks drain out.
// Output channel (m_valid/m_ready/m_data): one mark per pixel, with its row and
// column, trailing the input by one row plus one pixel. end_of_frame is set on
// the mark of the frame's last pixel; all position counters then restart.
// Configuration: cfg_we/cfg_index/cfg_wdata write width, height, threshold and
// pixel limit; write only while the block is idle.
// Throughput: one item per cycle. Each item does one read and one write on each
// of the two line memories; a same-column read that collides with the previous
// item's write is forwarded.
// Output path: a mark goes through the stage-1 registers into the output queue.
// Stall: a two-entry output queue takes the result while the receiver stalls;
// s_ready drops only when the queue would otherwise overflow.
// Reset: counters, window and registers return to defaults at once; the line
// memories are not cleared (unwritten entries only feed border marks).
module box_mean_3x3_threshold_mark
    import bm3t_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pixel_in_t            s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mark_out_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int LW    = $clog2(MAX_WIDTH + 2);
    localparam int CS_W  = PIX_W + 2;
    localparam int SUM_W = PIX_W + 4;
    localparam int T9_W  = THR_W + 4;
    localparam int CMP_W = (SUM_W > T9_W) ? SUM_W : T9_W;

    // Configuration registers
    logic [FWIDTH_W-1:0]  frame_width_reg;
    logic [FHEIGHT_W-1:0] frame_height_reg;
    logic [THR_W-1:0]     mean_threshold_reg;
    logic [PIX_W-1:0]     pixel_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg    <= FRAME_WIDTH_RST;
            frame_height_reg   <= FRAME_HEIGHT_RST;
            mean_threshold_reg <= MEAN_THRESHOLD_RST;
            pixel_limit_reg    <= PIXEL_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_wdata[FWIDTH_W-1:0];
                CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_wdata[FHEIGHT_W-1:0];
                CFG_MEAN_THRESHOLD: mean_threshold_reg <= cfg_wdata[THR_W-1:0];
                CFG_PIXEL_LIMIT:    pixel_limit_reg    <= cfg_wdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size
    logic [WW-1:0]        w_eff;
    logic [FHEIGHT_W-1:0] h_eff;

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(frame_width_reg);
        end
        h_eff = (frame_height_reg == '0) ? FHEIGHT_W'(1) : frame_height_reg;
    end

    // ------------------------------------------------------------------
    // Stage 0: position counters, clamp, line memory read
    // ------------------------------------------------------------------
    logic             s_fire;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [LW-1:0]    lead_reg, lead_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic             emit, eof, interior;
    logic [PIX_W-1:0] pix_in;

    assign s_fire = s_valid && s_ready;

    always_comb begin
        // clamp, flush enters as zero
        if (s_data.mode == MODE_FLUSH) begin
            pix_in = '0;
        end else if (s_data.pixel_value > pixel_limit_reg) begin
            pix_in = pixel_limit_reg;
        end else begin
            pix_in = s_data.pixel_value;
        end

        emit     = lead_reg > LW'(w_eff);
        interior = (out_row_reg != '0) && (out_col_reg != '0) &&
                   (32'(out_row_reg) + 32'd1 < 32'(h_eff)) &&
                   (32'(out_col_reg) + 32'd1 < 32'(w_eff));
        eof      = 1'b0;

        in_col_next  = (32'(in_col_reg) + 32'd1 >= 32'(w_eff)) ? '0
                                                              : in_col_reg + 1'b1;
        lead_next    = lead_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;

        if (!emit) begin
            lead_next = lead_reg + 1'b1;
        end else if (32'(out_col_reg) + 32'd1 >= 32'(w_eff)) begin
            out_col_next = '0;
            if (32'(out_row_reg) + 32'd1 >= 32'(h_eff)) begin
                eof = 1'b1;
            end else begin
                out_row_next = out_row_reg + 1'b1;
            end
        end else begin
            out_col_next = out_col_reg + 1'b1;
        end

        // frame end: everything restarts
        if (eof) begin
            in_col_next  = '0;
            lead_next    = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            lead_reg    <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end else if (s_fire) begin
            in_col_reg  <= in_col_next;
            lead_reg    <= lead_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers
    // ------------------------------------------------------------------
    logic             p1_valid_reg;
    logic [COL_W-1:0] p1_addr_reg;
    logic [PIX_W-1:0] p1_pix_reg;
    logic             p1_emit_reg;
    logic             p1_eof_reg;
    logic             p1_interior_reg;
    logic [ROW_W-1:0] p1_row_reg;
    logic [COL_W-1:0] p1_col_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_upper_reg;
    logic [PIX_W-1:0] fwd_middle_reg;
    logic [PIX_W-1:0] upper_rd_reg;
    logic [PIX_W-1:0] middle_rd_reg;
    logic [PIX_W-1:0] cur_upper;
    logic [PIX_W-1:0] cur_middle;

    // read data, corrected for a write to the same column at the read edge
    assign cur_upper  = fwd_reg ? fwd_upper_reg  : upper_rd_reg;
    assign cur_middle = fwd_reg ? fwd_middle_reg : middle_rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            p1_valid_reg <= s_fire;
            if (s_fire) begin
                fwd_reg <= p1_valid_reg && (p1_addr_reg == in_col_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_addr_reg     <= in_col_reg;
            p1_pix_reg      <= pix_in;
            p1_emit_reg     <= emit;
            p1_eof_reg      <= eof;
            p1_interior_reg <= interior;
            p1_row_reg      <= out_row_reg;
            p1_col_reg      <= out_col_reg;
            fwd_upper_reg   <= cur_middle;
            fwd_middle_reg  <= p1_pix_reg;
        end
    end

    // Line memories: upper takes the old middle value, middle takes the new pixel
    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            upper_mem[p1_addr_reg]  <= cur_middle;
            middle_mem[p1_addr_reg] <= p1_pix_reg;
        end
        if (s_fire) begin
            upper_rd_reg  <= upper_mem[in_col_reg];
            middle_rd_reg <= middle_mem[in_col_reg];
        end
    end

    // Window kept as its two older column sums plus the incoming column
    logic [CS_W-1:0]  cs0_reg, cs1_reg;
    logic [CS_W-1:0]  new_col;
    logic [SUM_W-1:0] win_sum;
    logic [T9_W-1:0]  thr9;
    logic             marked;

    assign new_col = CS_W'(cur_upper) + CS_W'(cur_middle) + CS_W'(p1_pix_reg);
    assign win_sum = SUM_W'(cs0_reg) + SUM_W'(cs1_reg) + SUM_W'(new_col);
    assign thr9    = T9_W'({mean_threshold_reg, 3'b000}) + T9_W'(mean_threshold_reg);
    assign marked  = p1_interior_reg && (CMP_W'(win_sum) > CMP_W'(thr9));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs0_reg <= '0;
            cs1_reg <= '0;
        end else if (p1_valid_reg) begin
            cs0_reg <= cs1_reg;
            cs1_reg <= new_col;
        end
    end

    // ------------------------------------------------------------------
    // Output queue, two entries
    // ------------------------------------------------------------------
    mark_out_t  q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    mark_out_t  result;

    assign push = p1_valid_reg && p1_emit_reg;
    assign pop  = m_valid && m_ready;

    always_comb begin
        result.row          = p1_row_reg;
        result.column       = COLUMN_W'(p1_col_reg);
        result.marked       = marked;
        result.end_of_frame = p1_eof_reg;
    end

    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);
    // the accepted item may push in the next cycle: leave room for it
    assign s_ready  = cnt_next <= 2'd1;
    assign m_valid  = cnt_reg != 2'd0;
    assign m_data   = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= result;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2)
        else $error("output queue over capacity");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg != 2'd2) || pop)
        else $error("result pushed into a full queue");

    a_fwd_with_write: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && fwd_reg |-> $past(s_fire, 2))
        else $error("forward flag set without back-to-back transfers");

    a_eof_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && eof |=> p1_emit_reg && (lead_reg == '0) && (in_col_reg == '0))
        else $error("frame end did not restart the counters");

endmodule
